// File: rtl/pcf_pkg.sv
// Shared types, constants and helper functions of the Playfair digraph cipher.
package pcf_pkg;

    localparam int LETTER_W    = 5;
    localparam int SIDE        = 5;
    localparam int CELLS       = SIDE * SIDE;
    localparam int SQ_W        = CELLS * LETTER_W;
    localparam int ROWS_W      = 60;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 60;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [LETTER_W-1:0] LETTER_I       = 5'd8;
    localparam logic [LETTER_W-1:0] LETTER_J       = 5'd9;
    localparam logic [LETTER_W-1:0] DEFAULT_FILLER = 5'd23;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_LOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_MID    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_LAST    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FILLER       = 3'd4;

    // one digraph queued for the back end
    typedef struct packed {
        logic [LETTER_W-1:0] a;
        logic [LETTER_W-1:0] b;
        logic                dec;
        logic                last;
    } t_pair;

    // square position
    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
    } t_pos;

    // highest-numbered matching cell wins; no match gives row 0, col 0
    function automatic t_pos locate(input logic [SQ_W-1:0] square,
                                    input logic [LETTER_W-1:0] letter);
        t_pos pos;
        pos = '0;
        for (int r = 0; r < SIDE; r++) begin
            for (int c = 0; c < SIDE; c++) begin
                if (square[(r*SIDE + c)*LETTER_W +: LETTER_W] == letter) begin
                    pos.row = 3'(r);
                    pos.col = 3'(c);
                end
            end
        end
        return pos;
    endfunction

    // step one place modulo five, backward when decrypting
    function automatic logic [2:0] step5(input logic [2:0] x, input logic dec);
        logic [2:0] y;
        if (dec) begin
            y = (x == 3'd0) ? 3'd4 : x - 3'd1;
        end else begin
            y = (x == 3'd4) ? 3'd0 : x + 3'd1;
        end
        return y;
    endfunction

    function automatic logic [LETTER_W-1:0] cell_at(input logic [SQ_W-1:0] square,
                                                    input t_pos pos);
        logic [6:0] idx;
        idx = 7'({2'b00, pos.row}) * 7'd5 + 7'({4'b0000, pos.col});
        return square[idx*7'd5 +: LETTER_W];
    endfunction

endpackage

// File: rtl/pcf_intf.sv
// Handshake interfaces of the cipher: letter input, letter output, config write.
interface pcf_letter_if;
    logic       valid;
    logic       ready;
    logic [4:0] letter;
    logic       message_end;
    modport source (output valid, output letter, output message_end, input ready);
    modport sink   (input valid, input letter, input message_end, output ready);
endinterface

interface pcf_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] out_letter;
    logic       out_last;
    modport source (output valid, output out_letter, output out_last, input ready);
    modport sink   (input valid, input out_letter, input out_last, output ready);
endinterface

interface pcf_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [59:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/playfair_digraph_cipher_top.sv
// Top level of the Playfair digraph cipher: config registers, front, queue, back.
//
// Channels: i_in takes one letter word per handshake (letter 0..25, j folded
// to i, message_end on the final letter). o_out gives one cipher or plain
// letter word per handshake, out_last on the final letter of the message.
// i_cfg writes a register by index: 0 decrypt mode, 1 cells 0..11, 2 cells
// 12..23, 3 cell 24, 4 filler letter; other indexes are dropped. It is
// always ready and is meant to be written while the block is idle.
// The input word completing a pair passes the pair queue, the pair stage and
// the output register before the first letter of the pair is valid on o_out;
// the second letter follows. The back end emits one letter word per cycle
// while the receiver is ready; for a doubled final letter the front end
// queues its second pad pair from a pending register with i_in.ready low.
// Reset clears the held letter, the pair queue and the output register;
// config returns to encrypt mode, all-zero square and filler x.
// When the receiver stalls, the output register holds its word, the back
// end stops popping, the queue fills and the front drops i_in.ready.
module playfair_digraph_cipher_top #(
    parameter int QUEUE_DEPTH = pcf_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pcf_letter_if.sink  i_in,
    pcf_out_if.source   o_out,
    pcf_cfg_if.sink     i_cfg
);
    import pcf_pkg::*;

    // config registers
    logic                  r_dec;
    logic [ROWS_W-1:0]     r_cells_low;
    logic [ROWS_W-1:0]     r_cells_mid;
    logic [LETTER_W-1:0]   r_cell_last;
    logic [LETTER_W-1:0]   r_fill;
    logic [SQ_W-1:0]       square;

    logic  q_full, q_valid, q_push, q_pop;
    t_pair q_push_data, q_head;

    assign i_cfg.ready = 1'b1;
    assign square      = {r_cell_last, r_cells_mid, r_cells_low};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec       <= 1'b0;
            r_cells_low <= '0;
            r_cells_mid <= '0;
            r_cell_last <= '0;
            r_fill      <= DEFAULT_FILLER;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_DECRYPT_MODE: r_dec       <= i_cfg.data[0];
                REG_CELLS_LOW:    r_cells_low <= i_cfg.data;
                REG_CELLS_MID:    r_cells_mid <= i_cfg.data;
                REG_CELL_LAST:    r_cell_last <= i_cfg.data[LETTER_W-1:0];
                REG_FILLER:       r_fill      <= i_cfg.data[LETTER_W-1:0];
                default: ;
            endcase
        end
    end

    // digraph forming
    pcf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_dec       (r_dec),
        .i_fill      (r_fill),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    pcf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .i_pop       (q_pop),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .o_head      (q_head)
    );

    // square lookup and letter output
    pcf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_square (square),
        .i_valid  (q_valid),
        .i_head   (q_head),
        .o_pop    (q_pop),
        .o_out    (o_out)
    );

endmodule

// File: rtl/pcf_front.sv
// Front end: takes letters, forms digraphs and pushes them into the pair queue.
module pcf_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    pcf_letter_if.sink                    i_in,
    input  logic                          i_dec,
    input  logic [pcf_pkg::LETTER_W-1:0]  i_fill,
    input  logic                          i_full,
    output logic                          o_push,
    output pcf_pkg::t_pair                o_push_data
);
    import pcf_pkg::*;

    logic [LETTER_W-1:0] r_held,   n_held;
    logic                r_held_v, n_held_v;
    t_pair               r_pend,   n_pend;
    logic                r_pend_v, n_pend_v;

    logic [LETTER_W-1:0] l;
    logic                accept;

    assign i_in.ready = !r_pend_v && !i_full;
    assign accept     = i_in.valid && i_in.ready;
    assign l          = (i_in.letter == LETTER_J) ? LETTER_I : i_in.letter;

    always_comb begin
        n_held      = r_held;
        n_held_v    = r_held_v;
        n_pend      = r_pend;
        n_pend_v    = r_pend_v;
        o_push      = 1'b0;
        o_push_data = '0;
        if (r_pend_v) begin
            // second pad pair of a doubled final letter
            if (!i_full) begin
                o_push      = 1'b1;
                o_push_data = r_pend;
                n_pend_v    = 1'b0;
            end
        end else if (accept) begin
            if (!r_held_v) begin
                if (i_in.message_end) begin
                    o_push      = 1'b1;
                    o_push_data = '{a: l, b: i_fill, dec: i_dec, last: 1'b1};
                end else begin
                    n_held   = l;
                    n_held_v = 1'b1;
                end
            end else if (i_dec || l != r_held) begin
                o_push      = 1'b1;
                o_push_data = '{a: r_held, b: l, dec: i_dec, last: i_in.message_end};
                n_held_v    = 1'b0;
            end else begin
                // doubled letter: pad the held one, new one starts the next pair
                o_push      = 1'b1;
                o_push_data = '{a: r_held, b: i_fill, dec: 1'b0, last: 1'b0};
                if (i_in.message_end) begin
                    n_pend   = '{a: l, b: i_fill, dec: 1'b0, last: 1'b1};
                    n_pend_v = 1'b1;
                    n_held_v = 1'b0;
                end else begin
                    n_held = l;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= '0;
            r_held_v <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_held   <= n_held;
            r_held_v <= n_held_v;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

endmodule

// File: rtl/pcf_queue.sv
// Short register queue of digraphs between front and back end.
module pcf_queue #(
    parameter int DEPTH = pcf_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pcf_pkg::t_pair i_push_data,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output pcf_pkg::t_pair o_head
);
    import pcf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_pair           r_mem [DEPTH];
    logic [AW-1:0]   r_wr, n_wr;
    logic [AW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

// File: rtl/pcf_back.sv
// Back end: locates a digraph in the square and emits its two letters.
module pcf_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [pcf_pkg::SQ_W-1:0]   i_square,
    input  logic                       i_valid,
    input  pcf_pkg::t_pair             i_head,
    output logic                       o_pop,
    pcf_out_if.source                  o_out
);
    import pcf_pkg::*;

    // pair stage: located positions
    t_pos                r_p1, n_p1;
    t_pos                r_p2, n_p2;
    logic                r_dec, n_dec;
    logic                r_last, n_last;
    logic                r_pv, n_pv;
    logic                r_ph, n_ph;
    // output register
    logic                r_ov, n_ov;
    logic [LETTER_W-1:0] r_ol, n_ol;
    logic                r_olast, n_olast;

    logic load;
    t_pos o1, o2;

    assign load = !r_ov || o_out.ready;
    assign o_pop = i_valid && (!r_pv || (load && r_ph));

    always_comb begin
        o1 = r_p1;
        o2 = r_p2;
        if (r_p1.row == r_p2.row) begin
            o1.col = step5(r_p1.col, r_dec);
            o2.col = step5(r_p2.col, r_dec);
        end else if (r_p1.col == r_p2.col) begin
            o1.row = step5(r_p1.row, r_dec);
            o2.row = step5(r_p2.row, r_dec);
        end else begin
            o1.col = r_p2.col;
            o2.col = r_p1.col;
        end
    end

    always_comb begin
        n_p1    = r_p1;
        n_p2    = r_p2;
        n_dec   = r_dec;
        n_last  = r_last;
        n_pv    = r_pv;
        n_ph    = r_ph;
        n_ov    = r_ov;
        n_ol    = r_ol;
        n_olast = r_olast;
        if (load) begin
            n_ov = r_pv;
            if (r_pv) begin
                n_ol    = r_ph ? cell_at(i_square, o2) : cell_at(i_square, o1);
                n_olast = r_ph && r_last;
                n_ph    = !r_ph;
                if (r_ph) begin
                    n_pv = 1'b0;
                end
            end
        end
        if (o_pop) begin
            n_p1   = locate(i_square, i_head.a);
            n_p2   = locate(i_square, i_head.b);
            n_dec  = i_head.dec;
            n_last = i_head.last;
            n_pv   = 1'b1;
            n_ph   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_ph <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_pv <= n_pv;
            r_ph <= n_ph;
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1    <= n_p1;
        r_p2    <= n_p2;
        r_dec   <= n_dec;
        r_last  <= n_last;
        r_ol    <= n_ol;
        r_olast <= n_olast;
    end

    assign o_out.valid      = r_ov;
    assign o_out.out_letter = r_ol;
    assign o_out.out_last   = r_olast;

endmodule

// File: tb/playfair_digraph_cipher_top_tb.sv
// Self-checking testbench of the Playfair digraph cipher top level.
`timescale 1ns / 100ps

module playfair_digraph_cipher_top_tb;
    import pcf_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;  // far above the slowest legal run
    localparam int SETTLE_CYCLES = 8;
    localparam int RAND_PHASES   = 9;
    localparam int PHASE_LETTERS = 36;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // one output letter word as the receiver sees it
    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                last;
    } t_cipher_word;

    // Mirrors the key registers and the held letter; predicts the output words.
    class cipher_scoreboard;
        logic                decrypt;
        logic [59:0]         cells_lo;
        logic [59:0]         cells_mid;
        logic [LETTER_W-1:0] cell_last;
        logic [LETTER_W-1:0] filler;
        logic [LETTER_W-1:0] held;
        logic                held_v;
        t_cipher_word        cipher_words_q[$];
        int                  errors;
        int                  words_in;
        int                  words_out;

        function new();
            decrypt   = 1'b0;
            cells_lo  = '0;
            cells_mid = '0;
            cell_last = '0;
            filler    = DEFAULT_FILLER;
            held      = '0;
            held_v    = 1'b0;
            errors    = 0;
            words_in  = 0;
            words_out = 0;
        endfunction

        function logic [LETTER_W-1:0] cell_code(int k);
            if (k < 12) return cells_lo[5*k +: 5];
            if (k < 24) return cells_mid[5*(k-12) +: 5];
            return cell_last;
        endfunction

        // last matching cell wins, no match sits at cell 0
        function int find_cell(logic [LETTER_W-1:0] l);
            int pos;
            pos = 0;
            for (int k = 0; k < CELLS; k++) begin
                if (cell_code(k) == l) pos = k;
            end
            return pos;
        endfunction

        function void queue_pair(logic [LETTER_W-1:0] a, logic [LETTER_W-1:0] b,
                                 logic dec, logic last);
            int pa, pb, r1, c1, r2, c2, shift, o1, o2;
            pa = find_cell(a);
            pb = find_cell(b);
            r1 = pa / SIDE;
            c1 = pa % SIDE;
            r2 = pb / SIDE;
            c2 = pb % SIDE;
            shift = dec ? SIDE - 1 : 1;
            if (r1 == r2) begin
                o1 = r1 * SIDE + (c1 + shift) % SIDE;
                o2 = r2 * SIDE + (c2 + shift) % SIDE;
            end else if (c1 == c2) begin
                o1 = ((r1 + shift) % SIDE) * SIDE + c1;
                o2 = ((r2 + shift) % SIDE) * SIDE + c2;
            end else begin
                o1 = r1 * SIDE + c2;
                o2 = r2 * SIDE + c1;
            end
            cipher_words_q.push_back(t_cipher_word'{cell_code(o1), 1'b0});
            cipher_words_q.push_back(t_cipher_word'{cell_code(o2), last});
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [59:0] d);
            case (idx)
                REG_DECRYPT_MODE: decrypt   = d[0];
                REG_CELLS_LOW:    cells_lo  = d;
                REG_CELLS_MID:    cells_mid = d;
                REG_CELL_LAST:    cell_last = d[4:0];
                REG_FILLER:       filler    = d[4:0];
                default: ;
            endcase
        endfunction

        function void note_letter(logic [LETTER_W-1:0] raw, logic msg_end);
            logic [LETTER_W-1:0] l;
            l = (raw == LETTER_J) ? LETTER_I : raw;
            words_in++;
            if (!held_v) begin
                if (msg_end) begin
                    queue_pair(l, filler, decrypt, 1'b1);
                end else begin
                    held   = l;
                    held_v = 1'b1;
                end
            end else if (decrypt || l != held) begin
                held_v = 1'b0;
                queue_pair(held, l, decrypt, msg_end);
            end else begin
                // doubled letter while encrypting: pad the held one, restart on the new one
                queue_pair(held, filler, 1'b0, 1'b0);
                if (msg_end) begin
                    held_v = 1'b0;
                    queue_pair(l, filler, 1'b0, 1'b1);
                end else begin
                    held = l;
                end
            end
        endfunction

        function void check_word(logic [LETTER_W-1:0] l, logic last);
            t_cipher_word exp_w;
            words_out++;
            if (cipher_words_q.size() == 0) begin
                $error("output word with none expected: out_letter=%0d out_last=%0d", l, last);
                errors++;
                return;
            end
            exp_w = cipher_words_q.pop_front();
            if (l !== exp_w.letter) begin
                $error("out_letter mismatch: expected %0d, actual %0d", exp_w.letter, l);
                errors++;
            end
            if (last !== exp_w.last) begin
                $error("out_last mismatch: expected %0d, actual %0d", exp_w.last, last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   steady;       // both sides run without gaps while set
    int   cycle_count;

    // working copy of the key square, row-major
    logic [LETTER_W-1:0] key_cells [CELLS];

    cipher_scoreboard sb;

    pcf_letter_if in_if ();
    pcf_out_if    out_if ();
    pcf_cfg_if    cfg_if ();

    playfair_digraph_cipher_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost word ends the run here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Monitor: every handshake is seen at the edge with pre-edge values,
    // so the order of processes within the step does not matter.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.index, cfg_if.data);
            if (in_if.valid && in_if.ready) sb.note_letter(in_if.letter, in_if.message_end);
            if (out_if.valid && out_if.ready) sb.check_word(out_if.out_letter, out_if.out_last);
        end
    end

    // Receiver: before each output word it holds ready low for a random stall.
    initial begin
        int stall;
        forever begin
            stall = steady ? 0 : $urandom_range(0, 15);
            if (stall != 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_if.valid && i_rst_n));
        end
    end

    function automatic logic [59:0] rand60();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[59:0];
    endfunction

    // random junk above the w bits the register keeps
    function automatic logic [59:0] with_junk(logic [59:0] v, int w);
        logic [59:0] m;
        m = ~60'd0 << w;
        return (rand60() & m) | v;
    endfunction

    // Sender: random gap before each letter word; valid stays high across
    // back-to-back words.
    task automatic send_letter(logic [LETTER_W-1:0] l, logic msg_end);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.letter      <= l;
        in_if.message_end <= msg_end;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [59:0] d);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= d;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop sending, wait for every expected word, then let the pipe empty.
    // The first edge lets the monitor note the word taken at the last edge.
    task automatic settle();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.cipher_words_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // a..z without j, in order
    task automatic order_square();
        int n;
        n = 0;
        for (int c = 0; c < 26; c++) begin
            if (c != LETTER_J) begin
                key_cells[n] = LETTER_W'(c);
                n++;
            end
        end
    endtask

    task automatic shuffle_square();
        int j;
        logic [LETTER_W-1:0] t;
        order_square();
        for (int i = CELLS - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = key_cells[i];
            key_cells[i] = key_cells[j];
            key_cells[j] = t;
        end
    endtask

    task automatic load_square();
        logic [59:0] lo, mid;
        for (int k = 0; k < 12; k++) begin
            lo[5*k +: 5]  = key_cells[k];
            mid[5*k +: 5] = key_cells[12+k];
        end
        write_reg(REG_CELLS_LOW, lo);
        write_reg(REG_CELLS_MID, mid);
        write_reg(REG_CELL_LAST, with_junk(60'(key_cells[CELLS-1]), LETTER_W));
    endtask

    initial begin
        int sent, len, pick, phases;
        logic [LETTER_W-1:0] l, prev, fill;

        sb = new();
        steady = 1'b0;
        phases = 0;
        i_rst_n           <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.letter      <= '0;
        in_if.message_end <= 1'b0;
        cfg_if.valid      <= 1'b0;
        cfg_if.index      <= '0;
        cfg_if.data       <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset square is all zeros: z is nowhere in it, a is everywhere.
        send_letter(5'd25, 1'b1);
        settle();

        // Ordered square: a b c d e / f g h i k / l m n o p / q r s t u / v w x y z
        order_square();
        load_square();
        send_letter(5'd0, 1'b0);    // a e: same row
        send_letter(5'd4, 1'b0);
        send_letter(5'd1, 1'b0);    // b w: same column
        send_letter(5'd22, 1'b0);
        send_letter(5'd2, 1'b0);    // c t: rectangle
        send_letter(5'd19, 1'b0);
        send_letter(5'd11, 1'b0);   // l l: doubled inside a message
        send_letter(5'd11, 1'b0);
        send_letter(5'd9, 1'b0);    // l j -> l i, then i z closes the message
        send_letter(5'd8, 1'b0);
        send_letter(5'd25, 1'b1);
        send_letter(5'd5, 1'b0);    // doubled final letter: two padded pairs
        send_letter(5'd5, 1'b1);
        send_letter(5'd16, 1'b1);   // lone final letter padded
        send_letter(5'd23, 1'b1);   // filler padding itself
        settle();

        // Decrypt with filler a: no digraph forming, odd tail paired with filler.
        write_reg(REG_DECRYPT_MODE, 60'd1);
        write_reg(REG_FILLER, 60'd0);
        send_letter(5'd0, 1'b0);
        send_letter(5'd4, 1'b0);
        send_letter(5'd7, 1'b0);
        send_letter(5'd7, 1'b0);
        send_letter(5'd12, 1'b1);
        // held letter carried across a switch back to encrypt
        send_letter(5'd3, 1'b0);
        settle();
        write_reg(REG_DECRYPT_MODE, 60'd0);
        send_letter(5'd3, 1'b1);
        settle();
        write_reg(REG_UNUSED, rand60());   // dropped by the block

        for (int p = 0; p < RAND_PHASES; p++) begin
            steady = (p == 4) || (p == 7);
            write_reg(REG_DECRYPT_MODE, with_junk(60'(p % 2), 1));
            if (p == 0) begin
                // cells 0..23 hold 31 and cell 24 holds z: only z is found, every word reads 31
                write_reg(REG_CELLS_LOW, ~60'd0);
                write_reg(REG_CELLS_MID, ~60'd0);
                write_reg(REG_CELL_LAST, 60'd25);
                fill = 5'd0;
            end else if (p == 1) begin
                write_reg(REG_CELLS_LOW, 60'd0);
                write_reg(REG_CELLS_MID, 60'd0);
                write_reg(REG_CELL_LAST, 60'd0);
                fill = 5'd25;
            end else if (p % 4 == 3) begin
                // raw cells: duplicates and codes above z
                write_reg(REG_CELLS_LOW, rand60());
                write_reg(REG_CELLS_MID, rand60());
                write_reg(REG_CELL_LAST, with_junk(60'($urandom_range(0, 25)), LETTER_W));
                fill = LETTER_W'($urandom_range(0, 25));
            end else begin
                shuffle_square();
                load_square();
                fill = LETTER_W'($urandom_range(0, 25));
            end
            write_reg(REG_FILLER, with_junk(60'(fill), LETTER_W));

            sent = 0;
            prev = '0;
            while (sent < PHASE_LETTERS) begin
                len = $urandom_range(1, 10);
                for (int k = 0; k < len; k++) begin
                    pick = $urandom_range(0, 15);
                    if (pick < 4 && k > 0) l = prev;           // force doubles
                    else if (pick == 4) l = LETTER_J;
                    else l = LETTER_W'($urandom_range(0, 25));
                    send_letter(l, k == len - 1);
                    prev = l;
                    sent++;
                end
            end
            // sender holds off until every word of the phase is out
            settle();
            phases++;
        end
        steady = 1'b0;
        settle();

        $display("Covered %0d letter words in and %0d out across %0d random key settings,",
                 sb.words_in, sb.words_out, phases);
        $display("both modes, empty and saturated squares, doubles and odd tails.");
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/pcf_pkg.sv
rtl/pcf_intf.sv
rtl/pcf_front.sv
rtl/pcf_queue.sv
rtl/pcf_back.sv
rtl/playfair_digraph_cipher_top.sv
tb/playfair_digraph_cipher_top_tb.sv
